FILE: rtl/core/wgtmax_pkg.sv
// Shared types, constants and saturation helper for the weight histogram block.
package wgtmax_pkg;

    localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    typedef struct packed {
        logic               command;
        logic [7:0]         obs_value;
        logic signed [31:0] obs_weight;
        logic [7:0]         scan_low;
        logic [7:0]         scan_high;
        logic               maximize;
    } item_t;

    typedef struct packed {
        logic signed [47:0] best_sum;
        logic [7:0]         best_first;
        logic [7:0]         best_last;
        logic               range_empty;
    } result_t;

    // Classified operation as it sits in the queue
    typedef struct packed {
        logic               is_scan;
        logic [7:0]         bin;
        logic signed [31:0] weight;
        logic [7:0]         lo;
        logic [7:0]         hi;
        logic               maximize;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } head_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v > 49'sh0_7FFF_FFFF_FFFF)
            r = SUM_MAX;
        else if (v < -49'sh0_8000_0000_0000)
            r = SUM_MIN;
        else
            r = v[47:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/wgtmax_ram.sv
// Generic single write port, single read port RAM with registered read (old data on collision).
module wgtmax_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/wgtmax_front.sv
// Front end: takes commands, drops out-of-range adds, and queues operations for the back end.
module wgtmax_front #(
    parameter int NUM_VALUES = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  wgtmax_pkg::item_t         item,
    input  wgtmax_pkg::back_status_t  status,
    output wgtmax_pkg::head_t         head,
    input  logic                      pop
);
    import wgtmax_pkg::*;

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    op_t             queue_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;

    logic            take;
    logic            keep;
    logic            push;
    op_t             op_in;

    assign take = start && !busy;
    // adds to bins beyond the histogram have no effect
    assign keep = (item.command == CMD_SCAN) ||
                  ({24'd0, item.obs_value} < 32'(NUM_VALUES));
    assign push = take && keep;

    always_comb
    begin
        op_in.is_scan  = (item.command == CMD_SCAN);
        op_in.bin      = item.obs_value;
        op_in.weight   = item.obs_weight;
        op_in.lo       = item.scan_low;
        op_in.hi       = item.scan_high;
        op_in.maximize = item.maximize;
    end

    assign busy = (count_reg == (PW+1)'(DEPTH)) || status.clearing;

    assign head.valid = (count_reg != '0);
    assign head.op    = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

FILE: rtl/core/wgtmax_back.sv
// Back end: histogram read-modify-write, range scan with clear, and reset clearing sweep.
module wgtmax_back #(
    parameter int NUM_VALUES = 256
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  wgtmax_pkg::head_t         head,
    output logic                      pop,
    output wgtmax_pkg::back_status_t  status,
    output logic                      done,
    output wgtmax_pkg::result_t       result
);
    import wgtmax_pkg::*;

    localparam int AW   = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
    localparam int WALK = (NUM_VALUES > 256) ? NUM_VALUES : 256;
    localparam int CW   = $clog2(WALK);

    typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_SCAN, ST_DRAIN} state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       idx_reg, idx_next;

    logic                add_valid_reg, add_valid_next;
    logic [AW-1:0]       add_addr_reg, add_addr_next;
    logic signed [31:0]  add_weight_reg, add_weight_next;

    logic                fwd_valid_reg, fwd_valid_next;
    logic [AW-1:0]       fwd_addr_reg, fwd_addr_next;
    logic signed [47:0]  fwd_data_reg, fwd_data_next;

    logic                sb_valid_reg, sb_valid_next;
    logic                sb_last_reg, sb_last_next;
    logic                sb_inmem_reg, sb_inmem_next;
    logic [CW-1:0]       sb_idx_reg, sb_idx_next;

    logic [7:0]          lo_reg, lo_next;
    logic [7:0]          hi_reg, hi_next;
    logic                max_reg, max_next;
    logic signed [47:0]  run_reg, run_next;
    logic signed [47:0]  best_reg, best_next;
    logic [7:0]          first_reg, first_next;
    logic [7:0]          last_reg, last_next;
    logic [7:0]          start_reg, start_next;
    logic                found_reg, found_next;

    logic                done_reg, done_next;
    result_t             result_reg, result_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic signed [47:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [47:0]         ram_rdata;

    logic                walk_inmem;
    logic                walk_end;
    logic [AW-1:0]       walk_addr;
    logic signed [47:0]  old_bin;
    logic signed [48:0]  add_sum;
    logic signed [47:0]  add_sat;
    logic signed [47:0]  bin_val;
    logic signed [48:0]  step_sum;
    logic signed [47:0]  run_sat;
    logic                in_range;
    logic                take_best;

    wgtmax_ram #(
        .WIDTH (48),
        .DEPTH (NUM_VALUES),
        .AW    (AW)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign walk_inmem = ({1'b0, idx_reg} < (CW+1)'(NUM_VALUES));
    assign walk_end   = (idx_reg == CW'(WALK - 1));
    assign walk_addr  = idx_reg[AW-1:0];

    // back-to-back adds to one bin: the RAM returns stale data, take last write
    assign old_bin = (fwd_valid_reg && (fwd_addr_reg == add_addr_reg))
                     ? fwd_data_reg : $signed(ram_rdata);
    assign add_sum = {old_bin[47], old_bin} + {{17{add_weight_reg[31]}}, add_weight_reg};
    assign add_sat = sat48(add_sum);

    // Kadane step; the running sum is never negative, so subtracting directly
    // in min mode matches negate-then-saturate
    assign bin_val   = sb_inmem_reg ? $signed(ram_rdata) : 48'sd0;
    assign step_sum  = max_reg ? ({run_reg[47], run_reg} + {bin_val[47], bin_val})
                               : ({run_reg[47], run_reg} - {bin_val[47], bin_val});
    assign run_sat   = sat48(step_sum);
    assign in_range  = (sb_idx_reg >= CW'(lo_reg)) && (sb_idx_reg <= CW'(hi_reg));
    assign take_best = !found_reg || (run_sat > best_reg);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = walk_addr;
        ram_wdata       = '0;
        ram_raddr       = walk_addr;

        add_valid_next  = 1'b0;
        add_addr_next   = add_addr_reg;
        add_weight_next = add_weight_reg;
        fwd_valid_next  = add_valid_reg;
        fwd_addr_next   = add_addr_reg;
        fwd_data_next   = add_sat;

        sb_valid_next   = 1'b0;
        sb_last_next    = 1'b0;
        sb_inmem_next   = sb_inmem_reg;
        sb_idx_next     = sb_idx_reg;

        lo_next         = lo_reg;
        hi_next         = hi_reg;
        max_next        = max_reg;
        run_next        = run_reg;
        best_next       = best_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        start_next      = start_reg;
        found_next      = found_reg;

        done_next       = 1'b0;
        result_next     = result_reg;

        if (add_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = add_addr_reg;
            ram_wdata = add_sat;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = walk_inmem;
                ram_waddr = walk_addr;
                ram_wdata = '0;
                idx_next  = idx_reg + 1'b1;
                if (walk_end)
                begin
                    idx_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (head.valid)
                begin
                    if (!head.op.is_scan)
                    begin
                        pop             = 1'b1;
                        ram_raddr       = AW'(head.op.bin);
                        add_valid_next  = 1'b1;
                        add_addr_next   = AW'(head.op.bin);
                        add_weight_next = head.op.weight;
                    end
                    else if (!add_valid_reg)
                    begin
                        // scan waits for the last add write to land
                        pop        = 1'b1;
                        lo_next    = head.op.lo;
                        hi_next    = head.op.hi;
                        max_next   = head.op.maximize;
                        run_next   = '0;
                        best_next  = SUM_MIN;
                        first_next = head.op.lo;
                        last_next  = head.op.hi;
                        start_next = head.op.lo;
                        found_next = 1'b0;
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // read old contents and zero the bin in the same cycle
                ram_raddr     = walk_addr;
                ram_we        = walk_inmem;
                ram_waddr     = walk_addr;
                ram_wdata     = '0;
                sb_valid_next = 1'b1;
                sb_idx_next   = idx_reg;
                sb_inmem_next = walk_inmem;
                sb_last_next  = walk_end;
                idx_next      = idx_reg + 1'b1;
                if (walk_end)
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase

        if (sb_valid_reg && in_range)
        begin
            run_next = run_sat;
            if (take_best)
            begin
                found_next = 1'b1;
                best_next  = run_sat;
                first_next = start_reg;
                last_next  = sb_idx_reg[7:0];
            end
            if (run_sat < 0)
            begin
                run_next   = '0;
                start_next = sb_idx_reg[7:0] + 8'd1;
            end
        end

        if (sb_valid_reg && sb_last_reg)
        begin
            done_next               = 1'b1;
            result_next.best_sum    = best_next;
            result_next.best_first  = first_next;
            result_next.best_last   = last_next;
            result_next.range_empty = (lo_reg > hi_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            idx_reg        <= '0;
            add_valid_reg  <= 1'b0;
            add_addr_reg   <= '0;
            add_weight_reg <= '0;
            fwd_valid_reg  <= 1'b0;
            fwd_addr_reg   <= '0;
            fwd_data_reg   <= '0;
            sb_valid_reg   <= 1'b0;
            sb_last_reg    <= 1'b0;
            sb_inmem_reg   <= 1'b0;
            sb_idx_reg     <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            max_reg        <= 1'b0;
            run_reg        <= '0;
            best_reg       <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
            start_reg      <= '0;
            found_reg      <= 1'b0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            add_valid_reg  <= add_valid_next;
            add_addr_reg   <= add_addr_next;
            add_weight_reg <= add_weight_next;
            fwd_valid_reg  <= fwd_valid_next;
            fwd_addr_reg   <= fwd_addr_next;
            fwd_data_reg   <= fwd_data_next;
            sb_valid_reg   <= sb_valid_next;
            sb_last_reg    <= sb_last_next;
            sb_inmem_reg   <= sb_inmem_next;
            sb_idx_reg     <= sb_idx_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            max_reg        <= max_next;
            run_reg        <= run_next;
            best_reg       <= best_next;
            first_reg      <= first_next;
            last_reg       <= last_next;
            start_reg      <= start_next;
            found_reg      <= found_next;
            done_reg       <= done_next;
            result_reg     <= result_next;
        end
    end

    assign status.clearing = (state_reg == ST_CLEAR);
    assign done            = done_reg;
    assign result          = result_reg;

endmodule

FILE: rtl/core/weight_histogram_max_subrange_top.sv
// Adds reach their bin via the queue and add register; one add per cycle while busy is low.
// A scan sweeps all max(NUM_VALUES, 256) bin indices (reading its range, zeroing every bin);
// done pulses once the last index has passed through the scan register.
// A 4-entry queue between front and back end absorbs commands while a scan runs.
// Reset: a clearing sweep over the histogram zeroes every bin, busy held high.
// Results are presented on done for one cycle; the receiver cannot stall them.
module weight_histogram_max_subrange_top #(
    parameter int NUM_VALUES = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  wgtmax_pkg::item_t    item,
    output logic                 done,
    output wgtmax_pkg::result_t  result
);
    import wgtmax_pkg::*;

    head_t         head;
    logic          pop;
    back_status_t  status;

    wgtmax_front #(
        .NUM_VALUES (NUM_VALUES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .status (status),
        .head   (head),
        .pop    (pop)
    );

    wgtmax_back #(
        .NUM_VALUES (NUM_VALUES)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .status (status),
        .done   (done),
        .result (result)
    );

    // a scan walks the whole histogram, so results never come in adjacent cycles
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done pulsed in consecutive cycles");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !status.clearing)
        else $error("result during reset clearing sweep");

    a_empty_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.range_empty) |-> (result.best_sum == SUM_MIN))
        else $error("empty range without most negative sum");

    a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.range_empty) |-> (result.best_first <= result.best_last))
        else $error("best run bounds out of order");

    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("queue popped while empty");

endmodule
